FILE: hdl/twp_pkg.sv
// ----------------------------------------------------------------------------
// twp_pkg
// Types, codes and constants shared by the tape waveform playback core.
// ----------------------------------------------------------------------------
`default_nettype none

package twp_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 4096;
  localparam int unsigned ENTRY_W         = 16;
  localparam int unsigned DUR_W           = 15;
  localparam int unsigned LEVEL_BIT       = 15;
  localparam int unsigned OFFSET_W        = 27;
  localparam int unsigned SUM_W           = OFFSET_W + 1;
  localparam int unsigned ALU_W           = 64;
  localparam int unsigned END_ALLOWANCE   = 17;

  typedef enum logic [2:0] {
    FUNC_LOAD      = 3'd0,
    FUNC_REWIND    = 3'd1,
    FUNC_MOTOR_ON  = 3'd2,
    FUNC_MOTOR_OFF = 3'd3,
    FUNC_QUERY     = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]       func;
    logic             entry_level;
    logic [DUR_W-1:0] entry_duration;
    logic [63:0]      cycle_now;
  } in_req_t;

  typedef struct packed {
    logic sample_level;
    logic pause_request;
    logic tape_ended;
  } out_rsp_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/twp_ram.sv
// ----------------------------------------------------------------------------
// twp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module twp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/twp_alu.sv
// ----------------------------------------------------------------------------
// twp_alu
// Shared 64-bit add/subtract unit; a subtract also reports the borrow,
// which serves as the less-than compare.
// ----------------------------------------------------------------------------
`default_nettype none

module twp_alu (
  input  wire twp_pkg::alu_req_t req,
  output twp_pkg::alu_rsp_t      rsp
);

  logic [twp_pkg::ALU_W-1:0] b_eff;
  logic [twp_pkg::ALU_W:0]   full;
  logic                      is_sub;

  assign is_sub = (req.op == twp_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~req.b : req.b;
  assign full   = {1'b0, req.a} + {1'b0, b_eff} + (twp_pkg::ALU_W + 1)'(is_sub);

  assign rsp.res    = full[twp_pkg::ALU_W-1:0];
  assign rsp.borrow = is_sub & ~full[twp_pkg::ALU_W];

endmodule

`default_nettype wire

FILE: hdl/tape_waveform_playback_core.sv
// ----------------------------------------------------------------------------
// tape_waveform_playback_core
// Cassette waveform player: run-length entries in a RAM, queried by cycle
// count through a small sequencer around one shared add/subtract unit.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid, in_stall, in_data    | request in
//   out     | out_valid, out_stall, out_data | result out
//   cfg     | cfg_wr_en, cfg_wr_data         | register write
//
// Load, rewind and motor requests pass through the execute and done states,
// and the result is registered from the done state. A sample query adds
// a position step and then, until the tape has ended or it stops on an
// entry, a RAM read, an add and a compare for every entry (add and compare
// through the shared unit), plus a resync step after a rewind or motor-on.
// Reset is synchronous; the RAM is not cleared since only loaded entries are
// read. A new request is taken while a result waits; a stalled output holds
// the next result in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_waveform_playback_core #(
  parameter int unsigned STORE_DEPTH = twp_pkg::STORE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire twp_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output twp_pkg::out_rsp_t     out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SYNC,
    S_POS,
    S_RD,
    S_ADD,
    S_CMP,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  twp_pkg::in_req_t                req_r, req_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [twp_pkg::OFFSET_W-1:0]    offset_r, offset_nxt;
  logic [63:0]                     origin_r, origin_nxt;
  logic [63:0]                     pos_r, pos_nxt;
  logic [twp_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic                            resync_r, resync_nxt;
  logic                            pause_en_r, pause_en_nxt;
  logic                            sample_r, sample_nxt;
  logic                            pause_r, pause_nxt;
  logic                            out_valid_r, out_valid_nxt;
  twp_pkg::out_rsp_t               out_data_r, out_data_nxt;

  twp_pkg::alu_req_t               alu_req;
  twp_pkg::alu_rsp_t               alu_rsp;

  logic                            ram_wr_en;
  logic                            ram_rd_en;
  logic [twp_pkg::ENTRY_W-1:0]     ram_rd_data;
  logic                            out_free;

  twp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  twp_ram #(
    .WIDTH (twp_pkg::ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({req_r.entry_level, req_r.entry_duration}),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign ram_wr_en = (state_r == S_EXEC) &&
                     (twp_pkg::func_t'(req_r.func) == twp_pkg::FUNC_LOAD) &&
                     (count_r < CW'(STORE_DEPTH));
  assign ram_rd_en = (state_r == S_RD) && (idx_r < count_r);

  always_comb begin
    alu_req = '{op: twp_pkg::ALU_ADD, a: '0, b: '0};
    case (state_r)
      S_SYNC: begin
        alu_req = '{op: twp_pkg::ALU_SUB, a: req_r.cycle_now, b: 64'(offset_r)};
      end
      S_POS: begin
        alu_req = '{op: twp_pkg::ALU_SUB, a: req_r.cycle_now, b: origin_r};
      end
      S_ADD: begin
        alu_req = '{op: twp_pkg::ALU_ADD, a: 64'(offset_r),
                    b: 64'(ram_rd_data[twp_pkg::DUR_W-1:0])};
      end
      S_CMP: begin
        alu_req = '{op: twp_pkg::ALU_SUB, a: pos_r, b: 64'(sum_r)};
      end
      default: begin
        alu_req = '{op: twp_pkg::ALU_ADD, a: '0, b: '0};
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    offset_nxt    = offset_r;
    origin_nxt    = origin_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    resync_nxt    = resync_r;
    pause_en_nxt  = cfg_wr_en ? cfg_wr_data : pause_en_r;
    sample_nxt    = sample_r;
    pause_nxt     = pause_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        sample_nxt = 1'b0;
        pause_nxt  = 1'b0;
        state_nxt  = S_DONE;
        case (twp_pkg::func_t'(req_r.func))
          twp_pkg::FUNC_LOAD: begin
            if (count_r < CW'(STORE_DEPTH)) begin
              count_nxt = count_r + CW'(1);
            end
          end
          twp_pkg::FUNC_REWIND: begin
            offset_nxt = '0;
            idx_nxt    = '0;
            resync_nxt = 1'b1;
          end
          twp_pkg::FUNC_MOTOR_ON: begin
            resync_nxt = 1'b1;
          end
          twp_pkg::FUNC_MOTOR_OFF: begin
            pause_nxt = pause_en_r && (count_r > CW'(twp_pkg::END_ALLOWANCE)) &&
                        (idx_r >= count_r - CW'(twp_pkg::END_ALLOWANCE));
          end
          twp_pkg::FUNC_QUERY: begin
            if (resync_r) begin
              resync_nxt = 1'b0;
              state_nxt  = S_SYNC;
            end else begin
              state_nxt = S_POS;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SYNC: begin
        origin_nxt = alu_rsp.res;
        state_nxt  = S_POS;
      end
      S_POS: begin
        pos_nxt   = alu_rsp.res;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (idx_r < count_r) begin
          state_nxt = S_ADD;
        end else begin
          sample_nxt = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_ADD: begin
        sum_nxt   = alu_rsp.res[twp_pkg::SUM_W-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (alu_rsp.borrow) begin
          sample_nxt = ram_rd_data[twp_pkg::LEVEL_BIT];
          state_nxt  = S_DONE;
        end else begin
          offset_nxt = sum_r[twp_pkg::OFFSET_W-1:0];
          idx_nxt    = idx_r + CW'(1);
          state_nxt  = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{sample_level: sample_r, pause_request: pause_r,
                            tape_ended: (idx_r >= count_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      offset_r    <= '0;
      origin_r    <= '0;
      resync_r    <= 1'b1;
      pause_en_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      offset_r    <= offset_nxt;
      origin_r    <= origin_nxt;
      resync_r    <= resync_nxt;
      pause_en_r  <= pause_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    pos_r      <= pos_nxt;
    sum_r      <= sum_nxt;
    sample_r   <= sample_nxt;
    pause_r    <= pause_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
